// File: design/swm_pkg.sv
// Shared types and constants for the sliding window maximum unit.
package swm_pkg;

    localparam int SAMPLE_WIDTH       = 16;
    localparam int WINDOW_LEN_WIDTH   = 7;
    localparam int DEFAULT_MAX_WINDOW = 64;

    // Input word: one sample and the end-of-sequence flag.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last;
    } src_word_t;

    // Output word: window maximum and the copied end flag.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] window_max;
        logic                           last_res;
    } dst_word_t;

endpackage

// File: design/swm_cell.sv
// One cell of the monotonic queue chain: holds one entry, shifts and evicts in place.
module swm_cell #(
    parameter int POS_WIDTH = 6
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   clear,
    input  logic                                   retire,
    input  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] sample,
    input  logic [POS_WIDTH-1:0]                   cur_pos,
    input  logic                                   right_valid,
    input  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] right_value,
    input  logic [POS_WIDTH-1:0]                   right_pos,
    input  logic                                   left_keep,
    output logic                                   keep,
    output logic                                   valid_reg,
    output logic signed [swm_pkg::SAMPLE_WIDTH-1:0] value_reg,
    output logic [POS_WIDTH-1:0]                   pos_reg,
    output logic signed [swm_pkg::SAMPLE_WIDTH-1:0] value_next
);
    import swm_pkg::*;

    logic                           cand_valid;
    logic signed [SAMPLE_WIDTH-1:0] cand_value;
    logic [POS_WIDTH-1:0]           cand_pos;
    logic                           valid_next;
    logic [POS_WIDTH-1:0]           pos_next;

    // Pick the entry this cell sees after the front retires
    always_comb
    begin
        if (retire)
        begin
            cand_valid = right_valid;
            cand_value = right_value;
            cand_pos   = right_pos;
        end
        else
        begin
            cand_valid = valid_reg;
            cand_value = value_reg;
            cand_pos   = pos_reg;
        end
    end

    // Keep the entry unless the new sample is strictly larger
    assign keep = cand_valid && (cand_value >= sample);

    // Take the new sample in the first cell whose entry was evicted
    always_comb
    begin
        if (keep)
        begin
            valid_next = 1'b1;
            value_next = cand_value;
            pos_next   = cand_pos;
        end
        else if (left_keep)
        begin
            valid_next = 1'b1;
            value_next = sample;
            pos_next   = cur_pos;
        end
        else
        begin
            valid_next = 1'b0;
            value_next = cand_value;
            pos_next   = cand_pos;
        end
    end

    // Drop the entry on clear, advance it on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until the next accepted word
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg <= value_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// File: design/sliding_window_maximum_unit.sv
// Sliding window maximum unit: top level with control, cell chain and output register.
//
// Usage: signed samples arrive on the src channel (src_valid, src_stall, src_data),
// one word per cycle while src_stall is low. From the window_len-th sample of a
// sequence on, each sample yields one word on the dst channel: the maximum of the
// latest window_len samples, with last_res copying the sample's last flag. Shorter
// sequences yield no word. An accepted word with last set ends the sequence and
// empties the queue. The queue is a chain of MAX_WINDOW cells, each holding one
// entry; all cells shift and evict together, sustaining one word per cycle while
// src_stall is low. dst_valid is registered and rises in the next cycle.
// The cfg channel (cfg_valid, cfg_ready, cfg_data) writes window_len; cfg_ready is
// always high, and a write also restarts the sequence. Write it only when idle.
// A window_len of zero acts as one; values above MAX_WINDOW act as MAX_WINDOW.
// Reset empties the queue, sets window_len to one and clears dst_valid.
// When dst_stall holds a pending result, src_stall rises in the same cycle and
// the pending word stays unchanged until it is taken.
module sliding_window_maximum_unit #(
    parameter int MAX_WINDOW = swm_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     src_valid,
    output logic                                     src_stall,
    input  swm_pkg::src_word_t                       src_data,
    output logic                                     dst_valid,
    input  logic                                     dst_stall,
    output swm_pkg::dst_word_t                       dst_data,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [swm_pkg::WINDOW_LEN_WIDTH-1:0]     cfg_data
);
    import swm_pkg::*;

    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (SW > WINDOW_LEN_WIDTH) ? SW : WINDOW_LEN_WIDTH;
    localparam int LW = SW + 1;

    logic [WINDOW_LEN_WIDTH-1:0] window_len_reg;
    logic [SW-1:0]               seen_reg;
    logic [SW-1:0]               seen_next;
    logic [PW-1:0]               pos_reg;
    logic [PW-1:0]               pos_next;
    logic                        dst_valid_reg;
    dst_word_t                   dst_data_reg;

    logic                        accept;
    logic                        cfg_write;
    logic                        clear;
    logic                        retire;
    logic                        result;
    logic [CW-1:0]               len_ext;
    logic [SW-1:0]               win;
    logic [LW-1:0]               leave_sum;
    logic [PW-1:0]               leaving;

    logic                        cell_valid [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
    logic [PW-1:0]               cell_pos [MAX_WINDOW];
    logic                        cell_keep [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] cell_value_next [MAX_WINDOW];

    // Handshakes
    assign src_stall = dst_valid_reg && dst_stall;
    assign accept    = src_valid && !src_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign clear     = cfg_write || (accept && src_data.last);

    // Clamp the window length to one through MAX_WINDOW
    always_comb
    begin
        len_ext = CW'(window_len_reg);
        if (len_ext == '0)
        begin
            win = SW'(1);
        end
        else if (len_ext > CW'(MAX_WINDOW))
        begin
            win = SW'(MAX_WINDOW);
        end
        else
        begin
            win = len_ext[SW-1:0];
        end
    end

    // Position leaving the window, modulo MAX_WINDOW
    always_comb
    begin
        leave_sum = LW'(pos_reg) + LW'(MAX_WINDOW) - LW'(win);
        if (leave_sum >= LW'(MAX_WINDOW))
        begin
            leave_sum = leave_sum - LW'(MAX_WINDOW);
        end
        leaving = leave_sum[PW-1:0];
    end

    // Retire the front entry once it falls out of the window
    assign retire = (seen_reg >= win) && cell_valid[0] && (cell_pos[0] == leaving);

    // Advance position and fill counters
    always_comb
    begin
        if (pos_reg == PW'(MAX_WINDOW - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + PW'(1);
        end
        if (seen_reg < win)
        begin
            seen_next = seen_reg + SW'(1);
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    assign result = seen_next >= win;

    // Chain of queue cells, front at index zero
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic                           right_valid;
        logic signed [SAMPLE_WIDTH-1:0] right_value;
        logic [PW-1:0]                  right_pos;
        logic                           left_keep;

        if (i == MAX_WINDOW - 1)
        begin : g_tail
            assign right_valid = 1'b0;
            assign right_value = cell_value[i];
            assign right_pos   = cell_pos[i];
        end
        else
        begin : g_body
            assign right_valid = cell_valid[i+1];
            assign right_value = cell_value[i+1];
            assign right_pos   = cell_pos[i+1];
        end

        if (i == 0)
        begin : g_head
            assign left_keep = 1'b1;
        end
        else
        begin : g_link
            assign left_keep = cell_keep[i-1];
        end

        swm_cell #(
            .POS_WIDTH (PW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (accept),
            .clear       (clear),
            .retire      (retire),
            .sample      (src_data.sample),
            .cur_pos     (pos_reg),
            .right_valid (right_valid),
            .right_value (right_value),
            .right_pos   (right_pos),
            .left_keep   (left_keep),
            .keep        (cell_keep[i]),
            .valid_reg   (cell_valid[i]),
            .value_reg   (cell_value[i]),
            .pos_reg     (cell_pos[i]),
            .value_next  (cell_value_next[i])
        );
    end

    // Window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_WIDTH'(1);
        end
        else if (cfg_write)
        begin
            window_len_reg <= cfg_data;
        end
    end

    // Sequence counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            pos_reg  <= '0;
        end
        else if (clear)
        begin
            seen_reg <= '0;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            seen_reg <= seen_next;
            pos_reg  <= pos_next;
        end
    end

    // Output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            dst_valid_reg <= result;
        end
        else if (!dst_stall)
        begin
            dst_valid_reg <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (accept && result)
        begin
            dst_data_reg.window_max <= cell_value_next[0];
            dst_data_reg.last_res   <= src_data.last;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

endmodule

// File: design/swm_checker.sv
// Port-level checker for the sliding window maximum unit, with its bind.
module swm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               src_valid,
    input logic               src_stall,
    input swm_pkg::src_word_t src_data,
    input logic               dst_valid,
    input logic               dst_stall,
    input swm_pkg::dst_word_t dst_data
);
    import swm_pkg::*;

    // A stalled result word stays presented
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid)
        else $error("dst word dropped while stalled");

    // A stalled result word keeps its payload
    a_dst_stable: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> $stable(dst_data))
        else $error("dst word changed while stalled");

    // Input stalls only behind a pending result
    a_src_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !dst_valid |-> !src_stall)
        else $error("src stalled with empty output register");

    // A new result follows an accepted sample
    a_dst_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(src_valid && !src_stall))
        else $error("result word without an accepted sample");

    // A stalled input word stays offered unchanged
    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |=> src_valid && $stable(src_data))
        else $error("src word changed while stalled");

endmodule

bind sliding_window_maximum_unit swm_checker u_swm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
);
